### design/rrrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replica balancer package
// Shared constants, payload types and controller/datapath command structs.
// ----------------------------------------------------------------------------
package rrrb_pkg;

   localparam int MAX_CLUSTERS      = 8;
   localparam int COUNT_WIDTH       = 8;
   localparam int NUM_REGIONS_DEF   = 4;
   localparam int SERVICE_COUNT_DEF = 16;
   localparam int RESULT_LIMIT      = 8;
   localparam int REGION_LIMIT      = 4;
   localparam int SERVICE_LIMIT     = 16;

   localparam int LANES  = (MAX_CLUSTERS < RESULT_LIMIT) ? MAX_CLUSTERS : RESULT_LIMIT;
   localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int NUM_W  = 4;
   localparam int GAP_W  = 11;
   localparam int PROD_W = COUNT_WIDTH + NUM_W;
   localparam int DIV_STEPS = GAP_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_CLUSTERS = 1'b0;
   localparam logic [NUM_W-1:0] CLUSTERS_RESET = 4'd8;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   localparam count_type COUNT_MAX = '1;

   typedef struct packed {
      logic [1:0]  region_id;
      logic [3:0]  service_id;
      logic [10:0] target_count;
   } req_type;

   typedef struct packed {
      logic [2:0] cluster_index;
      logic [7:0] new_count;
      logic       overflow;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic load;
      logic sum_step;
      logic gap_load;
      logic div_start;
      logic div_shrink;
      logic grow_apply;
      logic find_min;
      logic fill_step;
      logic shrink_apply;
      logic mem_write;
      logic out_step;
   } ctrl_type;

   typedef struct packed {
      logic req_ok;
      logic clear_last;
      logic sum_last;
      logic sum_eq;
      logic sum_lt;
      logic div_done;
      logic fill_fits;
      logic fill_done;
      logic out_last;
   } stat_type;

endpackage

### design/round_robin_replica_balancer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin replica balancer
// Sets a service's replica total in one region and reports per-cluster counts.
// ----------------------------------------------------------------------------
// After reset the block sweeps its count table, one row per cycle, over all
// NUM_REGIONS * SERVICE_COUNT rows (64 by default) with busy high. A request
// is taken when start is high and busy is low; busy then stays high until its
// last result has gone out. A request that needs no change goes from the sum
// straight to write-back and output. A grow divides the gap over the clusters
// in use. A shrink runs min-and-subtract rounds, each emptying the smallest
// nonempty clusters, then divides what is left of the gap over the clusters
// still nonempty unless the rounds used it up exactly. Results come on
// consecutive cycles, cluster 0 first, one per rsp_valid pulse; the receiver
// cannot stall them. A request naming a region or service beyond the table
// returns no result. Write clusters_in_use only while busy is low.
module round_robin_replica_balancer #(
   parameter int NUM_REGIONS   = rrrb_pkg::NUM_REGIONS_DEF,
   parameter int SERVICE_COUNT = rrrb_pkg::SERVICE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  rrrb_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output rrrb_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rrrb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rrrb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rrrb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import rrrb_pkg::*;

   ctrl_type              cmd;
   stat_type              st;
   logic [NUM_W-1:0]      clusters_ff, clusters_in;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic                  csr_write;

   always_comb begin
      csr_idx     = paddr[CSR_ADDR_W-1:2];
      csr_write   = psel && penable && pwrite && pready;
      clusters_in = clusters_ff;
      if (csr_write && (csr_idx == CSR_IDX_CLUSTERS)) begin
         clusters_in = pwdata[NUM_W-1:0];
      end
      if (csr_idx == CSR_IDX_CLUSTERS) begin
         prdata = CSR_DATA_W'(clusters_ff);
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff <= CLUSTERS_RESET;
      end else begin
         clusters_ff <= clusters_in;
      end
   end

   assign pready = 1'b1;

   rrrb_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .st    (st)
   );

   rrrb_datapath #(
      .NUM_REGIONS   (NUM_REGIONS),
      .SERVICE_COUNT (SERVICE_COUNT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_data     (req_data),
      .cfg_clusters (clusters_ff),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

### design/rrrb_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replica balancer divider
// Restoring divider, one quotient bit per cycle, gap by cluster count.
// ----------------------------------------------------------------------------
module rrrb_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rrrb_pkg::GAP_W-1:0]   dividend,
   input  logic [rrrb_pkg::NUM_W-1:0]   divisor,
   output logic                         done,
   output logic [rrrb_pkg::GAP_W-1:0]   quotient,
   output logic [rrrb_pkg::NUM_W-1:0]   remainder
);
   import rrrb_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [GAP_W-1:0]    quo_ff, quo_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]    div_ff, div_in;
   logic [NUM_W:0]      rem_sh;
   logic [NUM_W:0]      diff;
   logic                fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[GAP_W-1]};
      diff    = rem_sh - {1'b0, div_ff};
      fits    = (rem_sh >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[GAP_W-2:0], fits};
         rem_in = fits ? diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### design/rrrb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replica balancer datapath
// Count table, per-cluster lanes, sum, gap, water-fill and apply logic.
// ----------------------------------------------------------------------------
module rrrb_datapath #(
   parameter int NUM_REGIONS   = rrrb_pkg::NUM_REGIONS_DEF,
   parameter int SERVICE_COUNT = rrrb_pkg::SERVICE_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rrrb_pkg::ctrl_type           cmd,
   output rrrb_pkg::stat_type           st,
   input  rrrb_pkg::req_type            req_data,
   input  logic [rrrb_pkg::NUM_W-1:0]   cfg_clusters,
   output logic                         rsp_valid,
   output rrrb_pkg::rsp_type            rsp_data
);
   import rrrb_pkg::*;

   localparam int EFF_REGIONS  = (NUM_REGIONS < REGION_LIMIT) ? NUM_REGIONS : REGION_LIMIT;
   localparam int EFF_SERVICES = (SERVICE_COUNT < SERVICE_LIMIT) ? SERVICE_COUNT : SERVICE_LIMIT;
   localparam int ROWS   = EFF_REGIONS * EFF_SERVICES;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ROW_W  = LANES * COUNT_WIDTH;

   logic [ROW_W-1:0]   mem [ROWS];
   logic [ROW_W-1:0]   rd_ff;
   logic [ROW_AW-1:0]  addr_ff, addr_in;
   logic [ROW_AW-1:0]  clr_ff, clr_in;
   logic [GAP_W-1:0]   target_ff, target_in;
   logic [NUM_W-1:0]   n_ff, n_in;
   count_type          lane_ff [LANES];
   count_type          lane_in [LANES];
   logic [LANES-1:0]   flag_ff, flag_in;
   logic [GAP_W-1:0]   sum_ff, sum_in;
   logic [LANE_W-1:0]  idx_ff, idx_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   count_type          min_ff, min_in;
   logic [NUM_W-1:0]   nz_ff, nz_in;

   logic [ROW_AW-1:0]  req_addr;
   logic [NUM_W-1:0]   n_eff;
   logic [LANES-1:0]   in_use;
   logic [PROD_W-1:0]  prod;
   logic               wr_en;
   logic [ROW_AW-1:0]  wr_addr;
   logic [ROW_W-1:0]   wr_data;
   logic [GAP_W-1:0]   div_q;
   logic [NUM_W-1:0]   div_r;
   logic               div_done;

   rrrb_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (gap_ff),
      .divisor   (cmd.div_shrink ? nz_ff : n_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      req_addr = ROW_AW'(int'(req_data.region_id) * EFF_SERVICES
                 + int'(req_data.service_id));
      if (cfg_clusters == '0) begin
         n_eff = NUM_W'(1);
      end else if (cfg_clusters > NUM_W'(LANES)) begin
         n_eff = NUM_W'(LANES);
      end else begin
         n_eff = cfg_clusters;
      end
      for (int i = 0; i < LANES; i++) begin
         in_use[i] = (int'(n_ff) > i);
      end
      prod = PROD_W'(min_ff) * PROD_W'(nz_ff);
   end

   always_comb begin
      st.req_ok     = (int'(req_data.region_id) < EFF_REGIONS)
                      && (int'(req_data.service_id) < EFF_SERVICES);
      st.clear_last = (clr_ff == ROW_AW'(ROWS - 1));
      st.sum_last   = (idx_ff == LANE_W'(LANES - 1));
      st.sum_eq     = (sum_ff == target_ff);
      st.sum_lt     = (sum_ff < target_ff);
      st.div_done   = div_done;
      st.fill_fits  = (prod <= PROD_W'(gap_ff));
      st.fill_done  = (prod == PROD_W'(gap_ff));
      st.out_last   = ((NUM_W'(idx_ff) + NUM_W'(1)) == n_ff);
   end

   always_comb begin
      logic [GAP_W:0]    k;
      logic [GAP_W:0]    t;
      logic [GAP_W-1:0]  dec;
      logic [NUM_W-1:0]  rank;
      logic [NUM_W-1:0]  cnt;
      count_type         mn;

      addr_in   = addr_ff;
      clr_in    = clr_ff;
      target_in = target_ff;
      n_in      = n_ff;
      lane_in   = lane_ff;
      flag_in   = flag_ff;
      sum_in    = sum_ff;
      idx_in    = idx_ff;
      gap_in    = gap_ff;
      min_in    = min_ff;
      nz_in     = nz_ff;
      rank      = '0;
      cnt       = '0;
      mn        = COUNT_MAX;
      k         = '0;
      t         = '0;
      dec       = '0;

      if (cmd.clear) begin
         clr_in = clr_ff + ROW_AW'(1);
      end
      if (cmd.accept) begin
         addr_in   = req_addr;
         target_in = req_data.target_count;
         n_in      = n_eff;
      end
      if (cmd.load) begin
         for (int i = 0; i < LANES; i++) begin
            lane_in[i] = rd_ff[i*COUNT_WIDTH +: COUNT_WIDTH];
         end
         flag_in = '0;
         sum_in  = '0;
         idx_in  = '0;
      end
      if (cmd.sum_step) begin
         sum_in = sum_ff + (in_use[idx_ff] ? GAP_W'(lane_ff[idx_ff]) : '0);
         idx_in = idx_ff + LANE_W'(1);
      end
      if (cmd.gap_load) begin
         gap_in = st.sum_lt ? (target_ff - sum_ff) : (sum_ff - target_ff);
      end
      if (cmd.grow_apply) begin
         for (int i = 0; i < LANES; i++) begin
            k = {1'b0, div_q} + (GAP_W+1)'(NUM_W'(i) < div_r);
            t = (GAP_W+1)'(lane_ff[i]) + k;
            if (in_use[i]) begin
               if (t > (GAP_W+1)'(COUNT_MAX)) begin
                  lane_in[i] = COUNT_MAX;
                  flag_in[i] = 1'b1;
               end else begin
                  lane_in[i] = t[COUNT_WIDTH-1:0];
               end
            end
         end
      end
      if (cmd.find_min) begin
         for (int i = 0; i < LANES; i++) begin
            if (in_use[i] && (lane_ff[i] != '0)) begin
               cnt = cnt + NUM_W'(1);
               if (lane_ff[i] < mn) begin
                  mn = lane_ff[i];
               end
            end
         end
         min_in = mn;
         nz_in  = cnt;
      end
      if (cmd.fill_step && st.fill_fits) begin
         for (int i = 0; i < LANES; i++) begin
            if (in_use[i] && (lane_ff[i] != '0)) begin
               lane_in[i] = lane_ff[i] - min_ff;
            end
         end
         gap_in = gap_ff - prod[GAP_W-1:0];
      end
      if (cmd.shrink_apply) begin
         for (int i = 0; i < LANES; i++) begin
            dec = div_q + GAP_W'(rank < div_r);
            if (in_use[i] && (lane_ff[i] != '0)) begin
               lane_in[i] = lane_ff[i] - dec[COUNT_WIDTH-1:0];
               rank       = rank + NUM_W'(1);
            end
         end
      end
      if (cmd.mem_write) begin
         idx_in = '0;
      end
      if (cmd.out_step) begin
         idx_in = idx_ff + LANE_W'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         wr_data[i*COUNT_WIDTH +: COUNT_WIDTH] = cmd.clear ? '0 : lane_ff[i];
      end
      wr_en   = cmd.clear | cmd.mem_write;
      wr_addr = cmd.clear ? clr_ff : addr_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
      addr_ff   <= addr_in;
      target_ff <= target_in;
      n_ff      <= n_in;
      lane_ff   <= lane_in;
      flag_ff   <= flag_in;
      sum_ff    <= sum_in;
      idx_ff    <= idx_in;
      gap_ff    <= gap_in;
      min_ff    <= min_in;
      nz_ff     <= nz_in;
   end

   always_comb begin
      rsp_valid              = cmd.out_step;
      rsp_data.cluster_index = 3'(idx_ff);
      rsp_data.new_count     = 8'(lane_ff[idx_ff]);
      rsp_data.overflow      = flag_ff[idx_ff];
      rsp_data.last          = st.out_last;
   end

endmodule

### design/rrrb_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replica balancer controller
// Sequences clear sweep, read, sum, grow or shrink, write back and report.
// ----------------------------------------------------------------------------
module rrrb_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output rrrb_pkg::ctrl_type  cmd,
   input  rrrb_pkg::stat_type  st
);
   import rrrb_pkg::*;

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_READ   = 12'b0000_0000_0100,
      S_SUM    = 12'b0000_0000_1000,
      S_CMP    = 12'b0000_0001_0000,
      S_GSTART = 12'b0000_0010_0000,
      S_GDIV   = 12'b0000_0100_0000,
      S_MIN    = 12'b0000_1000_0000,
      S_FILL   = 12'b0001_0000_0000,
      S_SDIV   = 12'b0010_0000_0000,
      S_WRITE  = 12'b0100_0000_0000,
      S_OUT    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (st.req_ok) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.load = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (st.sum_last) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (st.sum_eq) begin
               state_in = S_WRITE;
            end else begin
               cmd.gap_load = 1'b1;
               state_in     = st.sum_lt ? S_GSTART : S_MIN;
            end
         end
         S_GSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_GDIV;
         end
         S_GDIV: begin
            if (st.div_done) begin
               cmd.grow_apply = 1'b1;
               state_in       = S_WRITE;
            end
         end
         S_MIN: begin
            cmd.find_min = 1'b1;
            state_in     = S_FILL;
         end
         S_FILL: begin
            if (st.fill_fits) begin
               cmd.fill_step = 1'b1;
               state_in      = st.fill_done ? S_WRITE : S_MIN;
            end else begin
               cmd.div_start  = 1'b1;
               cmd.div_shrink = 1'b1;
               state_in       = S_SDIV;
            end
         end
         S_SDIV: begin
            if (st.div_done) begin
               cmd.shrink_apply = 1'b1;
               state_in         = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            cmd.out_step = 1'b1;
            if (st.out_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
